/* design/tlbpt_pkg.sv */
// Package for the TLB / page-table translator.
// Holds widths, counter limits and the TLB entry type shared by the translator, its submodules and the testbench.
// No dependencies.
package tlbpt_pkg;

   localparam int TLB_DEPTH   = 16;
   localparam int PAGE_COUNT  = 256;
   localparam int ADDR_W      = 16;
   localparam int PAGE_W      = 8;
   localparam int OFFSET_W    = 8;
   localparam int FRAME_W     = 8;
   localparam int COUNT_W     = 32;
   localparam int NEXT_FREE_W = 9;

   localparam logic [NEXT_FREE_W-1:0] FRAME_LIMIT = NEXT_FREE_W'(PAGE_COUNT);
   localparam logic [COUNT_W-1:0]     COUNT_MAX   = {COUNT_W{1'b1}};

   typedef logic [PAGE_W-1:0]   page_type;
   typedef logic [FRAME_W-1:0]  frame_type;
   typedef logic [OFFSET_W-1:0] offset_type;
   typedef logic [COUNT_W-1:0]  count_type;

   // One TLB slot, handed from cell to cell on a push
   typedef struct packed {
      logic      valid;
      page_type  page;
      frame_type frame;
   } tlb_entry_type;

endpackage

/* design/tlb_page_table_translator.sv */
// On accept, the page-table read and the request are registered; in the resolve
// cycle the TLB lookup decides the frame and the result registers load, so rsp_valid
// rises in the cycle after the resolve cycle. A new request is taken only once resolve ends.
// busy is high during the resolve cycle. Synchronous reset clears the TLB,
// page-table valid bits, the free-frame pointer and all counters.
// The receiver cannot stall; results are never held off.
module tlb_page_table_translator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_virtual_address,
   output logic        rsp_valid,
   output logic [15:0] rsp_phys_addr,
   output logic        rsp_tlb_hit,
   output logic        rsp_page_fault,
   output logic [31:0] rsp_access_count,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_fault_count
);

   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   localparam int TD = tlbpt_pkg::TLB_DEPTH;

   state_type                           state_ff;
   logic                                busy_ff;
   tlbpt_pkg::page_type                 page_ff;
   tlbpt_pkg::offset_type               offset_ff;
   logic [tlbpt_pkg::NEXT_FREE_W-1:0]   next_free_ff, next_free_in;
   tlbpt_pkg::count_type                accesses_ff, accesses_in;
   tlbpt_pkg::count_type                hits_ff, hits_in;
   tlbpt_pkg::count_type                faults_ff, faults_in;
   logic                                rsp_valid_ff;
   logic [tlbpt_pkg::ADDR_W-1:0]        rsp_addr_ff;
   logic                                rsp_hit_ff;
   logic                                rsp_fault_ff;

   logic                                accept;
   logic                                resolve;
   logic [TD-1:0]                       match_vec;
   tlbpt_pkg::frame_type                frame_sel [TD];
   tlbpt_pkg::tlb_entry_type            cell_out [TD];
   tlbpt_pkg::tlb_entry_type            new_entry;
   tlbpt_pkg::frame_type                tlb_frame;
   logic                                tlb_hit;
   logic                                pt_valid;
   tlbpt_pkg::frame_type                pt_frame;
   tlbpt_pkg::frame_type                frame;
   logic                                fault;
   logic                                push;

   assign accept  = start && !busy_ff;
   assign resolve = (state_ff == ST_RESOLVE);

   // Page table, read on accept so data is ready in the resolve cycle
   tlbpt_page_table u_page_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_page   (req_virtual_address[15:8]),
      .rd_frame  (pt_frame),
      .chk_page  (page_ff),
      .chk_valid (pt_valid),
      .wr_en     (resolve && fault),
      .wr_page   (page_ff),
      .wr_frame  (frame)
   );

   // TLB as a chain of cells, new pair enters at slot 0
   assign new_entry = '{valid: 1'b1, page: page_ff, frame: frame};

   for (genvar i = 0; i < TD; i++) begin : g_cell
      tlbpt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (push),
         .lookup_page (page_ff),
         .entry_in    ((i == 0) ? new_entry : cell_out[(i == 0) ? 0 : i-1]),
         .entry_out   (cell_out[i]),
         .match       (match_vec[i]),
         .frame_sel   (frame_sel[i])
      );
   end

   // Valid entries hold distinct pages, so at most one slot matches
   always_comb begin
      tlb_frame = '0;
      for (int i = 0; i < TD; i++) begin
         tlb_frame = tlb_frame | frame_sel[i];
      end
   end

   assign tlb_hit = |match_vec;

   // Translation decision
   always_comb begin
      fault = !tlb_hit && !pt_valid;
      push  = resolve && !tlb_hit;
      if (tlb_hit) begin
         frame = tlb_frame;
      end else if (pt_valid) begin
         frame = pt_frame;
      end else begin
         frame = next_free_ff[tlbpt_pkg::FRAME_W-1:0];
      end
   end

   // Saturating counters and free-frame pointer
   always_comb begin
      accesses_in  = (accesses_ff == tlbpt_pkg::COUNT_MAX) ? accesses_ff
                                                          : accesses_ff + 32'd1;
      hits_in      = hits_ff;
      faults_in    = faults_ff;
      next_free_in = next_free_ff;
      if (tlb_hit && hits_ff != tlbpt_pkg::COUNT_MAX) begin
         hits_in = hits_ff + 32'd1;
      end
      if (fault) begin
         if (faults_ff != tlbpt_pkg::COUNT_MAX) begin
            faults_in = faults_ff + 32'd1;
         end
         if (next_free_ff < tlbpt_pkg::FRAME_LIMIT) begin
            next_free_in = next_free_ff + 9'd1;
         end
      end
   end

   // Sequencer, counters and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         next_free_ff <= '0;
         accesses_ff  <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  state_ff  <= ST_RESOLVE;
                  busy_ff   <= 1'b1;
                  page_ff   <= req_virtual_address[15:8];
                  offset_ff <= req_virtual_address[7:0];
               end
            end
            ST_RESOLVE: begin
               state_ff     <= ST_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
               rsp_addr_ff  <= {frame, offset_ff};
               rsp_hit_ff   <= tlb_hit;
               rsp_fault_ff <= fault;
               accesses_ff  <= accesses_in;
               hits_ff      <= hits_in;
               faults_ff    <= faults_in;
               next_free_ff <= next_free_in;
            end
            default: begin
               state_ff     <= ST_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phys_addr    = rsp_addr_ff;
   assign rsp_tlb_hit      = rsp_hit_ff;
   assign rsp_page_fault   = rsp_fault_ff;
   assign rsp_access_count = accesses_ff;
   assign rsp_hit_count    = hits_ff;
   assign rsp_fault_count  = faults_ff;

endmodule

/* design/tlbpt_cell.sv */
// One TLB slot of the FIFO shift chain: holds a page/frame pair, compares it
// against the page being looked up. Depends on tlbpt_pkg.
module tlbpt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    shift,
   input  tlbpt_pkg::page_type     lookup_page,
   input  tlbpt_pkg::tlb_entry_type entry_in,
   output tlbpt_pkg::tlb_entry_type entry_out,
   output logic                    match,
   output tlbpt_pkg::frame_type    frame_sel
);

   tlbpt_pkg::tlb_entry_type entry_ff;

   // Take the neighbor's entry on every push
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= entry_in;
      end
   end

   // A cleared slot never matches, not even page 0
   assign match     = entry_ff.valid && (entry_ff.page == lookup_page);
   assign frame_sel = match ? entry_ff.frame : '0;
   assign entry_out = entry_ff;

endmodule

/* design/tlbpt_page_table.sv */
// Page table: frame memory with registered read, plus a valid bit per page.
// Depends on tlbpt_pkg.
module tlbpt_page_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  tlbpt_pkg::page_type  rd_page,
   output tlbpt_pkg::frame_type rd_frame,
   input  tlbpt_pkg::page_type  chk_page,
   output logic                 chk_valid,
   input  logic                 wr_en,
   input  tlbpt_pkg::page_type  wr_page,
   input  tlbpt_pkg::frame_type wr_frame
);

   tlbpt_pkg::frame_type                  frame_mem_ff [tlbpt_pkg::PAGE_COUNT];
   tlbpt_pkg::frame_type                  rd_frame_ff;
   logic [tlbpt_pkg::PAGE_COUNT-1:0]      valid_ff;

   // Frame store: contents undefined until written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem_ff[wr_page] <= wr_frame;
      end
      if (rd_en) begin
         rd_frame_ff <= frame_mem_ff[rd_page];
      end
   end

   // Valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_page] <= 1'b1;
      end
   end

   assign rd_frame  = rd_frame_ff;
   assign chk_valid = valid_ff[chk_page];

endmodule

/* design/tlbpt_checker.sv */
// Port-level checker for the TLB / page-table translator, bound to the top.
// Depends on tlb_page_table_translator.
module tlbpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_tlb_hit,
   input logic        rsp_page_fault,
   input logic [31:0] rsp_hit_count,
   input logic [31:0] rsp_fault_count
);

   // An accepted request makes the block busy for exactly one cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_valid)
      else $error("busy cycle not followed by a single result");

   // A result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request");

   // Hit and fault exclude each other
   a_hit_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tlb_hit && rsp_page_fault))
      else $error("hit and fault in one result");

   // Counters reflect a flagged event
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tlb_hit || rsp_page_fault) |->
         (rsp_tlb_hit ? rsp_hit_count != 32'd0 : rsp_fault_count != 32'd0))
      else $error("event counter still zero");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_tlb_hit     (rsp_tlb_hit),
   .rsp_page_fault  (rsp_page_fault),
   .rsp_hit_count   (rsp_hit_count),
   .rsp_fault_count (rsp_fault_count)
);

/* sim/testbench.sv */
// Self-checking testbench for tlb_page_table_translator: drives virtual addresses
// over the start/busy handshake and checks each translation against a predictor.
// Depends on tlbpt_pkg and the translator RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF      = 2;
   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_REQUESTS = 1400;
   localparam int TAIL_REQUESTS   = 60;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int MAX_REPORTS     = 60;
   localparam int MAX_WORK_SET    = 24;

   // One translation as seen on the response ports
   typedef struct packed {
      logic [tlbpt_pkg::ADDR_W-1:0] phys_addr;
      logic                         tlb_hit;
      logic                         page_fault;
      tlbpt_pkg::count_type         access_count;
      tlbpt_pkg::count_type         hit_count;
      tlbpt_pkg::count_type         fault_count;
   } translation_type;

   // Mirror of the TLB, page table and counters plus the queue of pending translations
   class translation_scoreboard;
      tlbpt_pkg::tlb_entry_type          tlb_mirror [tlbpt_pkg::TLB_DEPTH];
      tlbpt_pkg::frame_type              table_frame [tlbpt_pkg::PAGE_COUNT];
      logic                              table_mapped [tlbpt_pkg::PAGE_COUNT];
      logic [tlbpt_pkg::NEXT_FREE_W-1:0] free_frame;
      tlbpt_pkg::count_type              accesses;
      tlbpt_pkg::count_type              hits;
      tlbpt_pkg::count_type              faults;
      translation_type                   pending_q [$];
      int                                errors;

      function new();
         for (int i = 0; i < tlbpt_pkg::TLB_DEPTH; i++) tlb_mirror[i] = '0;
         for (int i = 0; i < tlbpt_pkg::PAGE_COUNT; i++) begin
            table_frame[i]  = '0;
            table_mapped[i] = 1'b0;
         end
         free_frame = '0;
         accesses   = '0;
         hits       = '0;
         faults     = '0;
         errors     = 0;
      endfunction

      function tlbpt_pkg::count_type bump(tlbpt_pkg::count_type v);
         return (v == tlbpt_pkg::COUNT_MAX) ? v : v + 1'b1;
      endfunction

      // FIFO shift: newest pair enters at slot 0, last slot falls off
      function void tlb_insert(tlbpt_pkg::page_type page, tlbpt_pkg::frame_type frame);
         for (int i = tlbpt_pkg::TLB_DEPTH - 1; i > 0; i--) tlb_mirror[i] = tlb_mirror[i-1];
         tlb_mirror[0] = '{1'b1, page, frame};
      endfunction

      // Predict the translation of one accepted request
      function void note(logic [tlbpt_pkg::ADDR_W-1:0] va);
         tlbpt_pkg::page_type   page;
         tlbpt_pkg::offset_type offset;
         tlbpt_pkg::frame_type  frame;
         logic                  hit;
         logic                  fault;
         translation_type       t;
         page     = va[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
         offset   = va[tlbpt_pkg::OFFSET_W-1:0];
         frame    = '0;
         hit      = 1'b0;
         fault    = 1'b0;
         accesses = bump(accesses);
         // lowest matching valid slot wins; cleared slots never match
         for (int i = 0; i < tlbpt_pkg::TLB_DEPTH; i++) begin
            if (!hit && tlb_mirror[i].valid && tlb_mirror[i].page == page) begin
               frame = tlb_mirror[i].frame;
               hit   = 1'b1;
            end
         end
         if (hit) begin
            hits = bump(hits);
         end else if (table_mapped[page]) begin
            frame = table_frame[page];
            tlb_insert(page, frame);
         end else begin
            // page fault: hand out the next free frame
            fault               = 1'b1;
            frame               = free_frame[tlbpt_pkg::FRAME_W-1:0];
            table_frame[page]   = frame;
            table_mapped[page]  = 1'b1;
            tlb_insert(page, frame);
            if (free_frame < tlbpt_pkg::FRAME_LIMIT) free_frame = free_frame + 1'b1;
            faults = bump(faults);
         end
         t = '{{frame, offset}, hit, fault, accesses, hits, faults};
         pending_q.push_back(t);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: %s mismatch: expected %0h, actual %0h",
                        $time, field, want, got);
         end
      endfunction

      // Compare one strobed result with the oldest prediction
      function void check(translation_type got);
         translation_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t ns: result with no request pending: expected none, actual %0h",
                        $time, got);
            return;
         end
         want = pending_q.pop_front();
         compare("phys_addr", 32'(want.phys_addr), 32'(got.phys_addr));
         compare("tlb_hit", 32'(want.tlb_hit), 32'(got.tlb_hit));
         compare("page_fault", 32'(want.page_fault), 32'(got.page_fault));
         compare("access_count", want.access_count, got.access_count);
         compare("hit_count", want.hit_count, got.hit_count);
         compare("fault_count", want.fault_count, got.fault_count);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_virtual_address;
   logic        rsp_valid;
   logic [15:0] rsp_phys_addr;
   logic        rsp_tlb_hit;
   logic        rsp_page_fault;
   logic [31:0] rsp_access_count;
   logic [31:0] rsp_hit_count;
   logic [31:0] rsp_fault_count;

   translation_scoreboard board = new();
   int cycle_count = 0;
   int burst_left  = 0;

   tlb_page_table_translator u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_virtual_address  (req_virtual_address),
      .rsp_valid            (rsp_valid),
      .rsp_phys_addr        (rsp_phys_addr),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_access_count     (rsp_access_count),
      .rsp_hit_count        (rsp_hit_count),
      .rsp_fault_count      (rsp_fault_count)
   );

   always #CLOCK_HALF clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Monitor: note accepted requests, check strobed results
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note(req_virtual_address);
         if (rsp_valid)
            board.check('{rsp_phys_addr, rsp_tlb_hit, rsp_page_fault,
                          rsp_access_count, rsp_hit_count, rsp_fault_count});
      end
   end

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start               <= 1'b0;
         req_virtual_address <= 16'($urandom);
      end
   endtask

   // Present one request and hold it until the block takes it
   task automatic send_request(logic [15:0] va);
      @(negedge clock);
      start               <= 1'b1;
      req_virtual_address <= va;
      do @(posedge clock); while (busy);
   endtask

   // Sender works in bursts with random gaps in between
   task automatic issue(logic [15:0] va);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      end
      burst_left--;
      send_request(va);
   endtask

   // Hold off until every pending translation has come back
   task automatic wait_drained();
      idle_cycles(1);
      while (board.pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic directed_phase();
      issue(16'h0000);   // page 0 against a cleared TLB: must fault, not hit
      issue(16'h00FF);   // TLB hit on page 0
      issue(16'hFFFF);
      issue(16'hFF00);
      issue(16'hAA55);
      issue(16'h55AA);
      // sixteen fresh pages push the first four out of the TLB
      for (int p = 1; p <= tlbpt_pkg::TLB_DEPTH; p++)
         issue({tlbpt_pkg::page_type'(p), tlbpt_pkg::offset_type'(p * 17)});
      issue(16'h0080);   // page-table hit, refilled into TLB
      issue(16'hFF7F);
      issue(16'h0001);   // TLB hit again
   endtask

   // Mostly working sets (locality and TLB thrash), some uniform noise and hot pages
   task automatic random_phase();
      int                  sent;
      int                  mode;
      int                  set_size;
      bit                  drained_once;
      tlbpt_pkg::page_type hot;
      tlbpt_pkg::page_type work_set [MAX_WORK_SET];
      sent         = 0;
      drained_once = 1'b0;
      while (sent < RANDOM_REQUESTS) begin
         mode = $urandom_range(0, 99);
         if (mode < 60) begin
            set_size = $urandom_range(1, MAX_WORK_SET);
            for (int i = 0; i < set_size; i++) work_set[i] = tlbpt_pkg::page_type'($urandom);
            repeat ($urandom_range(4, 40)) begin
               issue({work_set[$urandom_range(0, set_size - 1)],
                      tlbpt_pkg::offset_type'($urandom)});
               sent++;
            end
         end else if (mode < 85) begin
            repeat ($urandom_range(1, 10)) begin
               issue(16'($urandom));
               sent++;
            end
         end else begin
            hot = tlbpt_pkg::page_type'($urandom);
            repeat ($urandom_range(2, 12)) begin
               issue({hot, tlbpt_pkg::offset_type'($urandom)});
               sent++;
            end
         end
         if (mode == 99 || (!drained_once && sent >= RANDOM_REQUESTS / 2)) begin
            wait_drained();
            drained_once = 1'b1;
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_virtual_address = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_phase();
      random_phase();
      // touch every page so the free-frame pointer runs out
      for (int p = 0; p < tlbpt_pkg::PAGE_COUNT; p++)
         issue({tlbpt_pkg::page_type'(p), tlbpt_pkg::offset_type'($urandom)});
      repeat (TAIL_REQUESTS) issue(16'($urandom));

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending_q.size() != 0) board.errors++;
      if (board.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
